/* rtl/core/brf_pkg.sv */
// Package for the bisection root finder: widths, codes, microcode table and fixed-point helpers.
package brf_pkg;

    localparam int WORD_W    = 32;
    localparam int STEP_W    = 7;
    localparam int CFG_IDX_W = 2;
    localparam int UPC_W     = 4;
    localparam int MAX_STEPS = 64;

    localparam logic signed [WORD_W-1:0] COEF_SQ_RST  = 32'sd65536;
    localparam logic signed [WORD_W-1:0] COEF_LIN_RST = -32'sd524288;
    localparam logic signed [WORD_W-1:0] COEF_CON_RST = 32'sd393216;
    localparam logic        [WORD_W-1:0] THRESH_RST   = 32'd4295;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEF_SQ  = 2'd0,
        CFG_COEF_LIN = 2'd1,
        CFG_COEF_CON = 2'd2,
        CFG_THRESH   = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_CONVERGED = 2'd0,
        ST_LIMIT     = 2'd1,
        ST_ZERO      = 2'd2
    } status_t;

    // Operand pair for the shared multiplier
    typedef enum logic [1:0] {
        MUL_XX    = 2'd0,
        MUL_CS_SQ = 2'd1,
        MUL_CL_X  = 2'd2,
        MUL_THR_M = 2'd3
    } mul_sel_t;

    // Sequencer branch operations
    typedef enum logic [2:0] {
        BR_NEXT    = 3'd0,
        BR_JUMP    = 3'd1,
        BR_IN      = 3'd2,
        BR_IF_INIT = 3'd3,
        BR_IF_DONE = 3'd4,
        BR_IF_OUT  = 3'd5
    } br_op_t;

    typedef logic [UPC_W-1:0] upc_t;

    // Microprogram addresses
    localparam upc_t UA_WAIT   = 4'd0;
    localparam upc_t UA_SQ_MUL = 4'd1;
    localparam upc_t UA_SQ_LD  = 4'd2;
    localparam upc_t UA_T2_MUL = 4'd3;
    localparam upc_t UA_T1_MUL = 4'd4;
    localparam upc_t UA_SUM    = 4'd5;
    localparam upc_t UA_FVAL   = 4'd6;
    localparam upc_t UA_UPD    = 4'd7;
    localparam upc_t UA_TEST   = 4'd8;
    localparam upc_t UA_MID    = 4'd9;
    localparam upc_t UA_OUT    = 4'd10;

    typedef struct packed {
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     sq_ld;
        logic     acc_ld;
        logic     acc_add;
        logic     fval_ld;
        logic     upd_en;
        logic     test_en;
        logic     mid_en;
        logic     out_en;
        br_op_t   br_op;
        upc_t     target;
    } ucw_t;

    // Control store: one word per microprogram step
    function automatic ucw_t ucode(input upc_t addr);
        ucw_t w;
        w = '0;
        case (addr)
            UA_WAIT:
            begin
                w.br_op = BR_IN;
            end
            UA_SQ_MUL:
            begin
                w.mul_en  = 1'b1;
                w.mul_sel = MUL_XX;
            end
            UA_SQ_LD:
            begin
                w.sq_ld = 1'b1;
            end
            UA_T2_MUL:
            begin
                w.mul_en  = 1'b1;
                w.mul_sel = MUL_CS_SQ;
            end
            UA_T1_MUL:
            begin
                w.acc_ld  = 1'b1;
                w.mul_en  = 1'b1;
                w.mul_sel = MUL_CL_X;
            end
            UA_SUM:
            begin
                w.acc_add = 1'b1;
            end
            UA_FVAL:
            begin
                w.fval_ld = 1'b1;
                w.br_op   = BR_IF_INIT;
                w.target  = UA_MID;
            end
            UA_UPD:
            begin
                w.upd_en  = 1'b1;
                w.mul_en  = 1'b1;
                w.mul_sel = MUL_THR_M;
            end
            UA_TEST:
            begin
                w.test_en = 1'b1;
                w.br_op   = BR_IF_DONE;
                w.target  = UA_OUT;
            end
            UA_MID:
            begin
                w.mid_en = 1'b1;
                w.br_op  = BR_JUMP;
                w.target = UA_SQ_MUL;
            end
            UA_OUT:
            begin
                w.out_en = 1'b1;
                w.br_op  = BR_IF_OUT;
                w.target = UA_WAIT;
            end
            default:
            begin
                w.br_op  = BR_JUMP;
                w.target = UA_WAIT;
            end
        endcase
        return w;
    endfunction

    // Q16.16 product: floor shift by 16, then saturate to 32 bits
    function automatic logic signed [WORD_W-1:0] qsat(input logic signed [63:0] p);
        logic signed [63:0] sh;
        sh = p >>> 16;
        if (sh > 64'sh0000_0000_7FFF_FFFF)
            return 32'sh7FFF_FFFF;
        else if (sh < -64'sh0000_0000_8000_0000)
            return 32'sh8000_0000;
        else
            return sh[WORD_W-1:0];
    endfunction

    // Saturate the 34-bit polynomial sum to 32 bits
    function automatic logic signed [WORD_W-1:0] sat34(input logic signed [33:0] s);
        if (s > 34'sh0_7FFF_FFFF)
            return 32'sh7FFF_FFFF;
        else if (s < -34'sh0_8000_0000)
            return 32'sh8000_0000;
        else
            return s[WORD_W-1:0];
    endfunction

endpackage

/* rtl/core/brf_stream_if.sv */
// Valid/ready channel interfaces for the query and result words.
interface brf_query_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [brf_pkg::WORD_W-1:0]    lower_bound;
    logic signed [brf_pkg::WORD_W-1:0]    upper_bound;

    modport source (output valid, output lower_bound, output upper_bound, input ready);
    modport sink   (input valid, input lower_bound, input upper_bound, output ready);
endinterface

interface brf_result_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [brf_pkg::WORD_W-1:0]    final_lower;
    logic signed [brf_pkg::WORD_W-1:0]    final_upper;
    logic        [brf_pkg::STEP_W-1:0]    step_count;
    logic        [1:0]                    status;

    modport source (output valid, output final_lower, output final_upper,
                    output step_count, output status, input ready);
    modport sink   (input valid, input final_lower, input final_upper,
                    input step_count, input status, output ready);
endinterface

/* rtl/core/bisection_root_finder_unit.sv */
// Bisection root finder for a quadratic in Q16.16, driven by a microcoded sequencer.
//
// Usage: a query word (lower_bound, upper_bound) enters on the query channel when
// valid and ready are both high; ready is high only while the sequencer waits for
// work, so one query is processed at a time. The block evaluates
// f(x) = coef_square*x^2 + coef_linear*x + coef_constant and bisects until the
// relative change of the midpoint falls to the threshold, the midpoint is zero,
// or 64 steps are done. One result word (final_lower, final_upper, step_count,
// status) leaves on the result channel.
// The query is taken when valid and ready meet; f(lower) is evaluated first, then
// each bisection step uses the one shared 33x33 multiplier four times. The result
// word and ready both return when the sequencer leaves its output step, so a new
// query is taken only after the previous one is finished.
// The result sits in an output register: the next query is accepted while it
// waits. If the receiver still holds the previous result when a new one is
// done, the sequencer waits in its output step.
// Reset: the sequencer returns to waiting, the output is emptied and the
// configuration registers take their default coefficients and threshold.
// Configuration: write cfg_data to register cfg_index while cfg_we is high.
module bisection_root_finder_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    brf_query_if.sink                      query,
    brf_result_if.source                   result,
    input  logic                           cfg_we,
    input  logic [brf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [brf_pkg::WORD_W-1:0]     cfg_data
);
    import brf_pkg::*;

    // Configuration registers
    logic signed [WORD_W-1:0] cs_reg, cl_reg, cc_reg;
    logic        [WORD_W-1:0] thr_reg;

    // Sequencer control state
    upc_t                upc_reg, upc_next;
    logic                init_reg, init_next;
    logic                out_valid_reg, out_valid_next;
    logic [STEP_W-1:0]   steps_reg, steps_next;

    // Datapath registers
    logic signed [WORD_W-1:0] lo_reg, lo_next;
    logic signed [WORD_W-1:0] hi_reg, hi_next;
    logic signed [WORD_W-1:0] fl_reg, fl_next;
    logic signed [WORD_W-1:0] fval_reg, fval_next;
    logic signed [WORD_W-1:0] prev_reg, prev_next;
    logic signed [WORD_W-1:0] m_reg, m_next;
    logic signed [WORD_W-1:0] x_reg, x_next;
    logic signed [WORD_W-1:0] sq_reg, sq_next;
    logic signed [33:0]       acc_reg, acc_next;
    logic signed [63:0]       prod_reg, prod_next;
    logic        [32:0]       d_reg, d_next;
    status_t                  stat_reg, stat_next;

    // Output register
    logic signed [WORD_W-1:0] olo_reg, olo_next;
    logic signed [WORD_W-1:0] ohi_reg, ohi_next;
    logic [STEP_W-1:0]        osteps_reg, osteps_next;
    status_t                  ostat_reg, ostat_next;

    ucw_t                cw;
    logic                in_fire;
    logic                slot_free;
    logic signed [32:0]  op_a, op_b;
    logic signed [65:0]  prod_full;
    logic signed [32:0]  m_abs, diff, mid_sum;
    logic [63:0]         d_shift;
    logic                moving, zero_mid, limit, done;
    status_t             stat_now;

    assign cw        = ucode(upc_reg);
    assign in_fire   = query.valid && query.ready;
    assign slot_free = !out_valid_reg || result.ready;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cs_reg  <= COEF_SQ_RST;
            cl_reg  <= COEF_LIN_RST;
            cc_reg  <= COEF_CON_RST;
            thr_reg <= THRESH_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_COEF_SQ:  cs_reg  <= cfg_data;
                CFG_COEF_LIN: cl_reg  <= cfg_data;
                CFG_COEF_CON: cc_reg  <= cfg_data;
                CFG_THRESH:   thr_reg <= cfg_data;
                default:      thr_reg <= thr_reg;
            endcase
        end
    end

    // Select multiplier operands
    always_comb
    begin
        m_abs = m_reg[WORD_W-1] ? -{m_reg[WORD_W-1], m_reg} : {m_reg[WORD_W-1], m_reg};
        case (cw.mul_sel)
            MUL_XX:
            begin
                op_a = {x_reg[WORD_W-1], x_reg};
                op_b = {x_reg[WORD_W-1], x_reg};
            end
            MUL_CS_SQ:
            begin
                op_a = {cs_reg[WORD_W-1], cs_reg};
                op_b = {sq_reg[WORD_W-1], sq_reg};
            end
            MUL_CL_X:
            begin
                op_a = {cl_reg[WORD_W-1], cl_reg};
                op_b = {x_reg[WORD_W-1], x_reg};
            end
            MUL_THR_M:
            begin
                op_a = {1'b0, thr_reg};
                op_b = m_abs;
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
        prod_full = op_a * op_b;
    end

    // Stop tests on the current midpoint
    always_comb
    begin
        d_shift  = {1'b0, d_reg[30:0], 32'b0};
        moving   = (d_reg[32:31] != 2'b00) || (d_shift > $unsigned(prod_reg));
        zero_mid = (m_reg == '0);
        limit    = (steps_reg >= STEP_W'(MAX_STEPS));
        done     = zero_mid || !moving || limit;
        if (zero_mid)
            stat_now = ST_ZERO;
        else if (!moving)
            stat_now = ST_CONVERGED;
        else
            stat_now = ST_LIMIT;
    end

    // Datapath next values under control of the current microword
    always_comb
    begin
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        fl_next     = fl_reg;
        fval_next   = fval_reg;
        prev_next   = prev_reg;
        m_next      = m_reg;
        x_next      = x_reg;
        sq_next     = sq_reg;
        acc_next    = acc_reg;
        prod_next   = prod_reg;
        d_next      = d_reg;
        stat_next   = stat_reg;
        steps_next  = steps_reg;
        init_next   = init_reg;
        olo_next    = olo_reg;
        ohi_next    = ohi_reg;
        osteps_next = osteps_reg;
        ostat_next  = ostat_reg;

        mid_sum = {lo_reg[WORD_W-1], lo_reg} + {hi_reg[WORD_W-1], hi_reg};
        diff    = {m_reg[WORD_W-1], m_reg} - {prev_reg[WORD_W-1], prev_reg};

        // Load a new query
        if (in_fire)
        begin
            lo_next    = query.lower_bound;
            hi_next    = query.upper_bound;
            x_next     = query.lower_bound;
            prev_next  = '0;
            steps_next = '0;
            init_next  = 1'b1;
        end

        if (cw.mul_en)
            prod_next = prod_full[63:0];
        if (cw.sq_ld)
            sq_next = qsat(prod_reg);
        if (cw.acc_ld)
            acc_next = 34'(qsat(prod_reg));
        if (cw.acc_add)
            acc_next = acc_reg + 34'(qsat(prod_reg)) + 34'(cc_reg);
        if (cw.fval_ld)
            fval_next = sat34(acc_reg);

        // Move one end of the interval
        if (cw.upd_en)
        begin
            steps_next = steps_reg + 1'b1;
            if ((fl_reg > 0 && fval_reg > 0) || (fl_reg < 0 && fval_reg < 0))
            begin
                lo_next = m_reg;
                fl_next = fval_reg;
            end
            else
            begin
                hi_next = m_reg;
            end
            d_next = diff[32] ? $unsigned(-diff) : $unsigned(diff);
        end

        if (cw.test_en)
        begin
            stat_next = stat_now;
            prev_next = m_reg;
        end

        // Take the midpoint; on the first pass latch f(lower)
        if (cw.mid_en)
        begin
            if (init_reg)
            begin
                fl_next   = fval_reg;
                init_next = 1'b0;
            end
            m_next = mid_sum[32:1];
            x_next = mid_sum[32:1];
        end

        if (cw.out_en && slot_free)
        begin
            olo_next    = lo_reg;
            ohi_next    = hi_reg;
            osteps_next = steps_reg;
            ostat_next  = stat_reg;
        end
    end

    // Sequencer next address and output handshake
    always_comb
    begin
        case (cw.br_op)
            BR_NEXT:    upc_next = upc_reg + 1'b1;
            BR_JUMP:    upc_next = cw.target;
            BR_IN:      upc_next = in_fire ? upc_reg + 1'b1 : upc_reg;
            BR_IF_INIT: upc_next = init_reg ? cw.target : upc_reg + 1'b1;
            BR_IF_DONE: upc_next = done ? cw.target : upc_reg + 1'b1;
            BR_IF_OUT:  upc_next = slot_free ? cw.target : upc_reg;
            default:    upc_next = UA_WAIT;
        endcase

        if (cw.out_en && slot_free)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg       <= UA_WAIT;
            init_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            steps_reg     <= '0;
        end
        else
        begin
            upc_reg       <= upc_next;
            init_reg      <= init_next;
            out_valid_reg <= out_valid_next;
            steps_reg     <= steps_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        fl_reg     <= fl_next;
        fval_reg   <= fval_next;
        prev_reg   <= prev_next;
        m_reg      <= m_next;
        x_reg      <= x_next;
        sq_reg     <= sq_next;
        acc_reg    <= acc_next;
        prod_reg   <= prod_next;
        d_reg      <= d_next;
        stat_reg   <= stat_next;
        olo_reg    <= olo_next;
        ohi_reg    <= ohi_next;
        osteps_reg <= osteps_next;
        ostat_reg  <= ostat_next;
    end

    assign query.ready        = (upc_reg == UA_WAIT);
    assign result.valid       = out_valid_reg;
    assign result.final_lower = olo_reg;
    assign result.final_upper = ohi_reg;
    assign result.step_count  = osteps_reg;
    assign result.status      = ostat_reg;

endmodule

/* rtl/core/brf_checker.sv */
// Port-level assertions for the bisection root finder, bound to the top level.
module brf_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [brf_pkg::STEP_W-1:0]  step_count,
    input logic [1:0]                  status
);
    import brf_pkg::*;

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    // Drop ready after taking a query
    a_one_query: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("query accepted while another is in progress");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> step_count != '0 && step_count <= STEP_W'(MAX_STEPS))
        else $error("step count out of range");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status == ST_CONVERGED || status == ST_LIMIT || status == ST_ZERO)
        else $error("undefined status code");

    a_limit_steps: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_LIMIT |-> step_count == STEP_W'(MAX_STEPS))
        else $error("step limit reported before the limit");

endmodule

bind bisection_root_finder_unit brf_checker u_brf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (query.valid),
    .in_ready   (query.ready),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .step_count (result.step_count),
    .status     (result.status)
);
